>>> rtl/core/aes_block_cipher_assert.svh
// Assertion macros for the AES block cipher core.
// Used by the top level; expects clk and rst_n in scope.
`ifndef AES_BLOCK_CIPHER_ASSERT_SVH
`define AES_BLOCK_CIPHER_ASSERT_SVH

// Same-cycle implication
`define AES_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("aes assertion failed");

// Next-cycle implication
`define AES_ASSERT_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("aes assertion failed");

`endif

>>> rtl/core/aes_pkg.sv
// Shared types, register indexes, S-box tables and round functions for the AES core.
// No dependencies.
package aes_pkg;

  typedef enum logic [1:0] {ST_IDLE, ST_KEXP, ST_LOAD, ST_ROUND} state_t;

  typedef enum logic [2:0] {
    CFG_KEY_MODE   = 3'd0,
    CFG_KEY_WORD_0 = 3'd1,
    CFG_KEY_WORD_1 = 3'd2,
    CFG_KEY_WORD_2 = 3'd3,
    CFG_KEY_WORD_3 = 3'd4
  } cfg_idx_t;

  typedef logic [7:0] byte_tbl_t [256];

  localparam logic [7:0] GF_POLY  = 8'h1b;
  localparam logic [7:0] INV_EXP  = 8'd254;

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] r;
    logic [7:0] x;
    logic [7:0] y;
    r = 8'h00;
    x = a;
    y = b;
    for (int k = 0; k < 8; k++) begin
      if (y[0]) r = r ^ x;
      x = x[7] ? ((x << 1) ^ GF_POLY) : (x << 1);
      y = y >> 1;
    end
    return r;
  endfunction

  function automatic logic [7:0] gf_inv(input logic [7:0] a);
    logic [7:0] r;
    r = 8'h01;
    for (int b = 7; b >= 0; b--) begin
      r = gf_mul(r, r);
      if (INV_EXP[b]) r = gf_mul(r, a);
    end
    return r;
  endfunction

  function automatic logic [7:0] rotl8(input logic [7:0] x, input int n);
    return (x << n) | (x >> (8 - n));
  endfunction

  function automatic byte_tbl_t gen_sbox();
    byte_tbl_t t;
    logic [7:0] b;
    for (int v = 0; v < 256; v++) begin
      b = gf_inv(v[7:0]);
      t[v] = b ^ rotl8(b, 1) ^ rotl8(b, 2) ^ rotl8(b, 3) ^ rotl8(b, 4) ^ 8'h63;
    end
    return t;
  endfunction

  function automatic byte_tbl_t gen_dec_sbox();
    byte_tbl_t t;
    logic [7:0] b;
    logic [7:0] x;
    for (int v = 0; v < 256; v++) begin
      x = v[7:0];
      b = rotl8(x, 1) ^ rotl8(x, 3) ^ rotl8(x, 6) ^ 8'h05;
      t[v] = gf_inv(b);
    end
    return t;
  endfunction

  localparam byte_tbl_t SBOX     = gen_sbox();
  localparam byte_tbl_t DEC_SBOX = gen_dec_sbox();

  // State byte n sits at bits [127-8n -: 8]; column c holds bytes 4c..4c+3
  function automatic logic [127:0] sub_bytes(input logic [127:0] s, input logic inv);
    logic [127:0] o;
    for (int n = 0; n < 16; n++)
      o[127-8*n -: 8] = inv ? DEC_SBOX[s[127-8*n -: 8]] : SBOX[s[127-8*n -: 8]];
    return o;
  endfunction

  function automatic logic [127:0] shift_rows(input logic [127:0] s, input logic inv);
    logic [127:0] o;
    int src;
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++) begin
        src = inv ? ((c + 4 - r) % 4) : ((c + r) % 4);
        o[127-8*(r+4*c) -: 8] = s[127-8*(r+4*src) -: 8];
      end
    return o;
  endfunction

  function automatic logic [127:0] mix_columns(input logic [127:0] s, input logic inv);
    logic [127:0] o;
    logic [7:0]   m [4];
    logic [7:0]   acc;
    m[0] = inv ? 8'd14 : 8'd2;
    m[1] = inv ? 8'd11 : 8'd3;
    m[2] = inv ? 8'd13 : 8'd1;
    m[3] = inv ? 8'd9  : 8'd1;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) begin
        acc = 8'h00;
        for (int k = 0; k < 4; k++)
          acc = acc ^ gf_mul(m[(k + 4 - r) % 4], s[127-8*(k+4*c) -: 8]);
        o[127-8*(r+4*c) -: 8] = acc;
      end
    return o;
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

endpackage

>>> rtl/core/aes_block_cipher.sv
// AES-128/256 block cipher: key expansion, round sequencer and output register.
// Depends on aes_pkg, aes_ram and aes_block_cipher_assert.svh.
//
// One 128-bit block per transaction, encrypt or decrypt chosen by in_tuser.
// For every block the key is expanded anew, one schedule word per cycle into
// a round-key RAM (44 words for AES-128, 60 for AES-256), then ST_LOAD
// primes the RAM read and the shared round unit applies one round per cycle
// (11 or 15 steps including the initial key addition); only the last round
// waits while the output register is still full. A new block is accepted only
// after the previous one has left the round unit, so throughput is set by the
// word-serial key schedule and the single round unit. in_tready is high only
// between blocks; a finished result waits in the output register while the
// next block is accepted and processed.
`include "aes_block_cipher_assert.svh"

module aes_block_cipher (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // [63:0] block_hi, [127:64] block_lo
  input  logic         in_tuser,   // cmd: 0 encrypt, 1 decrypt
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // [63:0] result_hi, [127:64] result_lo
  input  logic         cfg_we,
  input  logic [2:0]   cfg_addr,
  input  logic [63:0]  cfg_wdata
);

  aes_pkg::state_t state_r, state_nxt;

  logic         key_mode_r;
  logic [63:0]  key_r [4];
  logic [5:0]   wi_r, wi_nxt;
  logic [7:0]   rcon_r, rcon_nxt;
  logic [31:0]  win_r [8];
  logic [31:0]  win_nxt [8];
  logic [3:0]   step_r, step_nxt;
  logic         dec_r, dec_nxt;
  logic [127:0] st_r, st_nxt;
  logic         out_valid_r, out_valid_nxt;
  logic [127:0] out_data_r, out_data_nxt;

  logic [3:0]   nr;
  logic [5:0]   last_word;
  logic [2:0]   imod;
  logic         in_key;
  logic [31:0]  key_word;
  logic [31:0]  back_w;
  logic [31:0]  new_w;
  logic         ram_we;
  logic [3:0]   ram_raddr;
  logic [3:0]   rd_step;
  logic [127:0] rk;
  logic [127:0] enc_t;
  logic [127:0] dec_t;
  logic         last_step;
  logic         slot_free;

  assign nr        = key_mode_r ? 4'd14 : 4'd10;
  assign last_word = key_mode_r ? 6'd59 : 6'd43;
  assign imod      = key_mode_r ? wi_r[2:0] : {1'b0, wi_r[1:0]};
  assign in_key    = key_mode_r ? (wi_r < 6'd8) : (wi_r < 6'd4);
  assign key_word  = wi_r[0] ? key_r[wi_r[2:1]][31:0] : key_r[wi_r[2:1]][63:32];
  assign back_w    = key_mode_r ? win_r[0] : win_r[4];
  assign slot_free = !out_valid_r || out_tready;
  assign last_step = (step_r == nr);

  always_comb begin
    if (in_key)
      new_w = key_word;
    else if (imod == 3'd0)
      new_w = back_w ^ aes_pkg::sub_word({win_r[7][23:0], win_r[7][31:24]}) ^ {rcon_r, 24'h0};
    else if (key_mode_r && imod == 3'd4)
      new_w = back_w ^ aes_pkg::sub_word(win_r[7]);
    else
      new_w = back_w ^ win_r[7];
  end

  // Keep the last round key on the read port while the final round waits
  assign ram_we    = (state_r == aes_pkg::ST_KEXP) && (wi_r[1:0] == 2'd3);
  assign rd_step   = (state_r != aes_pkg::ST_ROUND) ? 4'd0 :
                     last_step ? step_r : step_r + 4'd1;
  assign ram_raddr = dec_r ? nr - rd_step : rd_step;

  aes_ram #(.WIDTH(128), .DEPTH(15)) u_rk_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wi_r[5:2]),
    .wdata ({win_r[5], win_r[6], win_r[7], new_w}),
    .raddr (ram_raddr),
    .rdata (rk)
  );

  // Shared round unit
  always_comb begin
    enc_t = aes_pkg::shift_rows(aes_pkg::sub_bytes(st_r, 1'b0), 1'b0);
    if (!last_step) enc_t = aes_pkg::mix_columns(enc_t, 1'b0);
    enc_t = enc_t ^ rk;
    dec_t = aes_pkg::sub_bytes(aes_pkg::shift_rows(st_r, 1'b1), 1'b1) ^ rk;
    if (!last_step) dec_t = aes_pkg::mix_columns(dec_t, 1'b1);
  end

  always_comb begin
    state_nxt     = state_r;
    wi_nxt        = wi_r;
    rcon_nxt      = rcon_r;
    win_nxt       = win_r;
    step_nxt      = step_r;
    dec_nxt       = dec_r;
    st_nxt        = st_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_tready;
    in_tready     = (state_r == aes_pkg::ST_IDLE);
    case (state_r)
      aes_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          st_nxt    = {in_tdata[63:0], in_tdata[127:64]};
          dec_nxt   = in_tuser;
          wi_nxt    = 6'd0;
          rcon_nxt  = 8'h01;
          state_nxt = aes_pkg::ST_KEXP;
        end
      end
      aes_pkg::ST_KEXP: begin
        for (int k = 0; k < 7; k++) win_nxt[k] = win_r[k+1];
        win_nxt[7] = new_w;
        if (!in_key && imod == 3'd0)
          rcon_nxt = rcon_r[7] ? ((rcon_r << 1) ^ aes_pkg::GF_POLY) : (rcon_r << 1);
        wi_nxt = wi_r + 6'd1;
        if (wi_r == last_word) state_nxt = aes_pkg::ST_LOAD;
      end
      aes_pkg::ST_LOAD: begin
        step_nxt  = 4'd0;
        state_nxt = aes_pkg::ST_ROUND;
      end
      aes_pkg::ST_ROUND: begin
        if (step_r == 4'd0) begin
          st_nxt   = st_r ^ rk;
          step_nxt = step_r + 4'd1;
        end else if (!last_step) begin
          st_nxt   = dec_r ? dec_t : enc_t;
          step_nxt = step_r + 4'd1;
        end else if (slot_free) begin
          // hold the last round until the output register frees up
          st_nxt        = dec_r ? dec_t : enc_t;
          out_data_nxt  = dec_r ? {dec_t[63:0], dec_t[127:64]} : {enc_t[63:0], enc_t[127:64]};
          out_valid_nxt = 1'b1;
          state_nxt     = aes_pkg::ST_IDLE;
        end
      end
      default: state_nxt = aes_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= aes_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      key_mode_r  <= 1'b0;
      for (int k = 0; k < 4; k++) key_r[k] <= 64'h0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          aes_pkg::CFG_KEY_MODE:   key_mode_r <= cfg_wdata[0];
          aes_pkg::CFG_KEY_WORD_0: key_r[0]   <= cfg_wdata;
          aes_pkg::CFG_KEY_WORD_1: key_r[1]   <= cfg_wdata;
          aes_pkg::CFG_KEY_WORD_2: key_r[2]   <= cfg_wdata;
          aes_pkg::CFG_KEY_WORD_3: key_r[3]   <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    wi_r       <= wi_nxt;
    rcon_r     <= rcon_nxt;
    win_r      <= win_nxt;
    step_r     <= step_nxt;
    dec_r      <= dec_nxt;
    st_r       <= st_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `AES_ASSERT_IMP(a_step_range, state_r == aes_pkg::ST_ROUND, step_r <= nr)
  `AES_ASSERT_NXT(a_accept_kexp, in_tvalid && in_tready, state_r == aes_pkg::ST_KEXP)
  `AES_ASSERT_NXT(a_finish_out,
    state_r == aes_pkg::ST_ROUND && step_r == nr && slot_free,
    out_valid_r && state_r == aes_pkg::ST_IDLE)

endmodule

>>> rtl/core/aes_ram.sv
// Generic single-port-write RAM with registered read.
// No dependencies.
module aes_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 15
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

>>> tb/aes_block_cipher_tb.sv
// Self-checking testbench for the AES-128/256 block cipher core.
// Predicts each block with a local AES model; depends on aes_pkg and the RTL.
`timescale 1ns / 1ps

module aes_block_cipher_tb;

  localparam int unsigned CYCLE_LIMIT = 2000000;
  localparam int unsigned SETTLE_CYCLES = 120;
  localparam int unsigned LONG_HOLD = 500;

  typedef struct packed {
    logic        decrypt;
    logic [63:0] blk_hi;
    logic [63:0] blk_lo;
  } blk_item_t;

  typedef struct packed {
    logic [63:0] res_hi;
    logic [63:0] res_lo;
  } blk_result_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [127:0] in_tdata;   // [63:0] block_hi, [127:64] block_lo
  logic         in_tuser;   // cmd: 0 encrypt, 1 decrypt
  logic         out_tvalid;
  logic         out_tready;
  logic [127:0] out_tdata;  // [63:0] result_hi, [127:64] result_lo
  logic         cfg_we;
  logic [2:0]   cfg_addr;
  logic [63:0]  cfg_wdata;

  aes_block_cipher u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // Local copy of the key registers
  logic        wide_key;
  logic [63:0] key_q [4];
  logic [31:0] sched [60];
  logic [7:0]  fwd_box [256];
  logic [7:0]  inv_box [256];

  blk_item_t   pending_q [$];
  blk_result_t result_q [$];
  int unsigned error_count;
  int unsigned cycle_count;
  int unsigned results_seen;
  int unsigned items_total;

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    acc = 8'h00;
    for (int k = 0; k < 8; k++) begin
      if (b[0]) acc ^= a;
      a = a[7] ? ((a << 1) ^ 8'h1b) : (a << 1);
      b = b >> 1;
    end
    return acc;
  endfunction

  function automatic logic [7:0] rol8(input logic [7:0] x, input int n);
    return (x << n) | (x >> (8 - n));
  endfunction

  // Field inverse as a^254; zero maps to zero
  function automatic void build_boxes();
    logic [7:0] inv;
    for (int v = 0; v < 256; v++) begin
      inv = 8'h01;
      for (int k = 0; k < 254; k++) inv = gmul(inv, v[7:0]);
      fwd_box[v] = inv ^ rol8(inv, 1) ^ rol8(inv, 2) ^ rol8(inv, 3) ^ rol8(inv, 4) ^ 8'h63;
    end
    for (int v = 0; v < 256; v++) inv_box[fwd_box[v]] = v[7:0];
  endfunction

  function automatic logic [31:0] sbox_word(input logic [31:0] w);
    return {fwd_box[w[31:24]], fwd_box[w[23:16]], fwd_box[w[15:8]], fwd_box[w[7:0]]};
  endfunction

  function automatic void expand_schedule(input int nk, input int nr);
    logic [31:0] t;
    logic [7:0]  rc;
    rc = 8'h01;
    for (int i = 0; i < nk; i++) sched[i] = key_q[i / 2][(i % 2) ? 31 : 63 -: 32];
    for (int i = nk; i < 4 * (nr + 1); i++) begin
      t = sched[i - 1];
      if (i % nk == 0) begin
        t = sbox_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
        rc = gmul(rc, 8'h02);
      end else if (nk > 6 && i % nk == 4) begin
        t = sbox_word(t);
      end
      sched[i] = sched[i - nk] ^ t;
    end
  endfunction

  function automatic void add_round(ref logic [7:0] st [16], input int rnd);
    for (int n = 0; n < 16; n++) st[n] ^= sched[4 * rnd + n / 4][31 - 8 * (n % 4) -: 8];
  endfunction

  function automatic void subst(ref logic [7:0] st [16], input logic inv);
    for (int n = 0; n < 16; n++) st[n] = inv ? inv_box[st[n]] : fwd_box[st[n]];
  endfunction

  function automatic void rotate_rows(ref logic [7:0] st [16], input logic inv);
    logic [7:0] t [16];
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++)
        t[r + 4 * c] = st[r + 4 * (inv ? (c + 4 - r) % 4 : (c + r) % 4)];
    st = t;
  endfunction

  function automatic void mix_cols(ref logic [7:0] st [16], input logic inv);
    logic [7:0] m [4];
    logic [7:0] o [16];
    if (inv) m = '{8'd14, 8'd11, 8'd13, 8'd9};
    else m = '{8'd2, 8'd3, 8'd1, 8'd1};
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) begin
        o[r + 4 * c] = 8'h00;
        for (int k = 0; k < 4; k++) o[r + 4 * c] ^= gmul(m[(k + 4 - r) % 4], st[k + 4 * c]);
      end
    st = o;
  endfunction

  function automatic blk_result_t cipher_block(input blk_item_t it);
    logic [7:0]  st [16];
    logic [127:0] flat;
    int          nr;
    blk_result_t res;
    nr = wide_key ? 14 : 10;
    expand_schedule(wide_key ? 8 : 4, nr);
    flat = {it.blk_hi, it.blk_lo};
    for (int n = 0; n < 16; n++) st[n] = flat[127 - 8 * n -: 8];
    if (!it.decrypt) begin
      add_round(st, 0);
      for (int rnd = 1; rnd <= nr; rnd++) begin
        subst(st, 1'b0);
        rotate_rows(st, 1'b0);
        if (rnd < nr) mix_cols(st, 1'b0);
        add_round(st, rnd);
      end
    end else begin
      add_round(st, nr);
      for (int rnd = nr - 1; rnd >= 0; rnd--) begin
        rotate_rows(st, 1'b1);
        subst(st, 1'b1);
        add_round(st, rnd);
        if (rnd > 0) mix_cols(st, 1'b1);
      end
    end
    for (int n = 0; n < 16; n++) flat[127 - 8 * n -: 8] = st[n];
    res.res_hi = flat[127:64];
    res.res_lo = flat[63:0];
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch at result %0d: %s got %h want %h", results_seen, what, got, want);
    error_count++;
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Sender: bursts of transactions separated by random gaps
  int unsigned burst_left;
  int unsigned gap_left;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid  <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
    end else if (!in_tvalid || in_tready) begin
      if (gap_left > 0) begin
        gap_left  <= gap_left - 1;
        in_tvalid <= 1'b0;
      end else if (pending_q.size() > 0) begin
        in_tvalid <= 1'b1;
        in_tuser  <= pending_q[0].decrypt;
        in_tdata  <= {pending_q[0].blk_lo, pending_q[0].blk_hi};
        void'(pending_q.pop_front());
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 12);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 90);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: changing stall patterns plus one long hold-off
  int unsigned hold_left;
  logic        long_hold_done;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready     <= 1'b0;
      hold_left      <= 0;
      long_hold_done <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (!long_hold_done && results_seen == 300) begin
      long_hold_done <= 1'b1;
      hold_left      <= LONG_HOLD;
      out_tready     <= 1'b0;
    end else begin
      case ((cycle_count / 512) % 3)
        0: out_tready <= 1'b1;
        1: out_tready <= 1'($urandom_range(0, 1));
        default: out_tready <= ($urandom_range(0, 5) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      result_q.insert(result_q.size(),
                      cipher_block('{in_tuser, in_tdata[63:0], in_tdata[127:64]}));
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (result_q.size() == 0) begin
        report_mismatch("unexpected result_hi", out_tdata[63:0], 64'h0);
      end else begin
        if (out_tdata[63:0] !== result_q[0].res_hi)
          report_mismatch("result_hi", out_tdata[63:0], result_q[0].res_hi);
        if (out_tdata[127:64] !== result_q[0].res_lo)
          report_mismatch("result_lo", out_tdata[127:64], result_q[0].res_lo);
        void'(result_q.pop_front());
      end
      results_seen++;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      aes_pkg::CFG_KEY_MODE:   wide_key = val[0];
      aes_pkg::CFG_KEY_WORD_0: key_q[0] = val;
      aes_pkg::CFG_KEY_WORD_1: key_q[1] = val;
      aes_pkg::CFG_KEY_WORD_2: key_q[2] = val;
      aes_pkg::CFG_KEY_WORD_3: key_q[3] = val;
      default: ;
    endcase
  endtask

  // Queue one item for the sender and count it as expected
  task automatic enqueue(input blk_item_t it);
    pending_q.insert(pending_q.size(), it);
    items_total++;
  endtask

  // Block the test sequence until every result is back, then let the core settle
  task automatic drain();
    while (results_seen < items_total) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_key(input logic mode, input logic [63:0] k0, input logic [63:0] k1,
                          input logic [63:0] k2, input logic [63:0] k3);
    write_reg(aes_pkg::CFG_KEY_MODE, {63'h0, mode});
    write_reg(aes_pkg::CFG_KEY_WORD_0, k0);
    write_reg(aes_pkg::CFG_KEY_WORD_1, k1);
    write_reg(aes_pkg::CFG_KEY_WORD_2, k2);
    write_reg(aes_pkg::CFG_KEY_WORD_3, k3);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic blk_item_t rand_item();
    blk_item_t it;
    it.decrypt = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 15))
      0: begin it.blk_hi = '0; it.blk_lo = '0; end
      1: begin it.blk_hi = '1; it.blk_lo = '1; end
      default: begin it.blk_hi = rand64(); it.blk_lo = rand64(); end
    endcase
    return it;
  endfunction

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = 1'b0;
    cfg_we      = 1'b0;
    cfg_addr    = '0;
    cfg_wdata   = '0;
    error_count = 0;
    cycle_count = 0;
    results_seen = 0;
    items_total = 0;
    wide_key    = 1'b0;
    foreach (key_q[i]) key_q[i] = '0;
    build_boxes();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset key: all-zero AES-128, extremes of the block
    enqueue('{1'b0, 64'h0, 64'h0});
    enqueue('{1'b1, 64'h0, 64'h0});
    enqueue('{1'b0, '1, '1});
    enqueue('{1'b1, '1, '1});
    drain();

    // Published AES-128 vector; key words 2 and 3 must be ignored
    load_key(1'b0, 64'h0001020304050607, 64'h08090a0b0c0d0e0f, '1, 64'h5a5a5a5a5a5a5a5a);
    enqueue('{1'b0, 64'h0011223344556677, 64'h8899aabbccddeeff});
    enqueue('{1'b1, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a});
    enqueue('{1'b1, 64'h0011223344556677, 64'h8899aabbccddeeff});
    drain();

    // Writes to unmapped indexes must leave the key alone
    for (int i = aes_pkg::CFG_KEY_WORD_3 + 1; i < 8; i++) write_reg(i[2:0], '1);
    enqueue('{1'b0, 64'h0011223344556677, 64'h8899aabbccddeeff});
    drain();

    // Published AES-256 vector
    load_key(1'b1, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
             64'h1011121314151617, 64'h18191a1b1c1d1e1f);
    enqueue('{1'b0, 64'h0011223344556677, 64'h8899aabbccddeeff});
    enqueue('{1'b1, 64'h8ea2b7ca516745bf, 64'heafc49904b496089});
    enqueue('{1'b0, 64'h0, 64'h0});
    enqueue('{1'b1, '1, '1});
    drain();

    // All-ones AES-256 key, then zero key back in AES-128
    load_key(1'b1, '1, '1, '1, '1);
    enqueue('{1'b0, '1, 64'h0});
    enqueue('{1'b1, 64'h0, '1});
    drain();
    load_key(1'b0, '0, '0, '0, '0);
    enqueue('{1'b1, 64'h8000000000000000, 64'h0000000000000001});
    drain();

    // Random phases, each with its own key and size
    for (int ph = 0; ph < 8; ph++) begin
      load_key(ph[0], rand64(), rand64(), rand64(), rand64());
      for (int n = 0; n < 135; n++) enqueue(rand_item());
      drain();
    end

    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
